>>> rtl/itp_pkg.sv
// Shared widths and constants for the IPv4 dotted-decimal text parser.
`timescale 1ns / 1ps

package itp_pkg;

   localparam int CHAR_W    = 8;
   localparam int ADDR_W    = 32;
   localparam int PART_W    = 24;
   localparam int OCTET_W   = 9;
   localparam int INDEX_W   = 2;
   localparam int DIGIT_W   = 4;
   localparam int SUM_W     = 12;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;
   localparam logic [OCTET_W-1:0] OCTET_MAX = 9'd255;
   localparam logic [OCTET_W-1:0] OCTET_SAT = 9'd256;
   localparam logic [INDEX_W-1:0] LAST_OCTET = 2'd3;

endpackage

>>> rtl/itp_req_if.sv
// Character channel into the parser: valid/ready plus one text byte and start flag.
`timescale 1ns / 1ps

interface itp_req_if;
   import itp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              start_req;

   modport source (output valid, output character, output start_req, input ready);
   modport sink   (input valid, input character, input start_req, output ready);
endinterface

>>> rtl/itp_rsp_if.sv
// Result channel out of the parser: valid/ready plus address and error flag.
`timescale 1ns / 1ps

interface itp_rsp_if;
   import itp_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;
   logic              parse_error;

   modport source (output valid, output address, output parse_error, input ready);
   modport sink   (input valid, input address, input parse_error, output ready);
endinterface

>>> rtl/ipv4_text_parser.sv
// Top level: dotted-decimal IPv4 text parser with a two-entry result buffer.
//
// Usage:
//   req_bus carries one ASCII character per transfer; start_req marks the
//   first character of a new address string and drops any parse in flight.
//   rsp_bus carries one result per string: the 32-bit address (first octet
//   in bits 31..24) with parse_error low, or zero with parse_error high.
//   The result is registered on the transfer of the character that ends
//   the fourth number, or of the first faulty one.
//   Characters after a result are ignored until the next start.
//   Throughput is one character per cycle unless stalled; the per-character
//   update is a single multiply-by-ten and add on the octet accumulator.
//   Results go to an output register backed by one skid entry, so req_bus
//   keeps accepting while a result waits; req_bus.ready drops only while
//   both entries are full, and rises again once rsp_bus takes a transfer.
//   Reset (synchronous, active high) empties the buffer and returns the
//   parser to idle with all accumulators cleared.
`timescale 1ns / 1ps

module ipv4_text_parser (
   input logic       clock,
   input logic       reset,
   itp_req_if.sink   req_bus,
   itp_rsp_if.source rsp_bus
);
   import itp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_EXPECT = 2'd1,
      PH_NUMBER = 2'd2
   } phase_type;

   phase_type            phase_ff,  phase_in;
   logic [INDEX_W-1:0]   index_ff,  index_in;
   logic [OCTET_W-1:0]   octet_ff,  octet_in;
   logic [PART_W-1:0]    part_ff,   part_in;

   logic                 out_valid_ff, skid_valid_ff;
   logic [ADDR_W-1:0]    out_addr_ff,  skid_addr_ff;
   logic                 out_err_ff,   skid_err_ff;

   logic                 accept, pop, push;
   logic                 is_digit;
   logic [DIGIT_W-1:0]   digit;
   logic [SUM_W-1:0]     sum;
   phase_type            phase_eff;
   logic [INDEX_W-1:0]   index_eff;
   logic [OCTET_W-1:0]   octet_eff;
   logic [PART_W-1:0]    part_eff;
   logic                 emit;
   logic [ADDR_W-1:0]    emit_addr;
   logic                 emit_err;

   assign req_bus.ready = !skid_valid_ff;
   assign accept = req_bus.valid && req_bus.ready;
   assign pop    = out_valid_ff && rsp_bus.ready;
   assign push   = accept && emit;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.address     = out_addr_ff;
   assign rsp_bus.parse_error = out_err_ff;

   assign is_digit = req_bus.character inside {[CHAR_ZERO:CHAR_NINE]};
   // low nibble of '0'..'9' is the digit value
   assign digit    = req_bus.character[DIGIT_W-1:0];
   assign sum      = SUM_W'(octet_eff) * SUM_W'(10) + SUM_W'(digit);

   always_comb begin
      // start restarts the string before this character is examined
      if (req_bus.start_req) begin
         phase_eff = PH_EXPECT;
         index_eff = '0;
         octet_eff = '0;
         part_eff  = '0;
      end else begin
         phase_eff = phase_ff;
         index_eff = index_ff;
         octet_eff = octet_ff;
         part_eff  = part_ff;
      end

      phase_in  = phase_eff;
      index_in  = index_eff;
      octet_in  = octet_eff;
      part_in   = part_eff;
      emit      = 1'b0;
      emit_addr = '0;
      emit_err  = 1'b0;

      case (phase_eff)
         PH_EXPECT: begin
            if (!is_digit) begin
               emit     = 1'b1;
               emit_err = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               octet_in = OCTET_W'(digit);
               phase_in = PH_NUMBER;
            end
         end
         PH_NUMBER: begin
            if (is_digit) begin
               octet_in = (sum > SUM_W'(OCTET_SAT)) ? OCTET_SAT : sum[OCTET_W-1:0];
            end else if (octet_eff > OCTET_MAX) begin
               emit     = 1'b1;
               emit_err = 1'b1;
               phase_in = PH_IDLE;
            end else if (index_eff == LAST_OCTET) begin
               emit      = 1'b1;
               emit_addr = {part_eff, octet_eff[7:0]};
               phase_in  = PH_IDLE;
            end else begin
               part_in  = {part_eff[PART_W-9:0], octet_eff[7:0]};
               index_in = index_eff + INDEX_W'(1);
               octet_in = '0;
               phase_in = PH_EXPECT;
            end
         end
         default: begin
            // idle, and the unused code, ignore the character
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         index_ff      <= '0;
         octet_ff      <= '0;
         part_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            index_ff <= index_in;
            octet_ff <= octet_in;
            part_ff  <= part_in;
         end

         if (skid_valid_ff) begin
            // no push possible here: ready is low
            if (pop) begin
               out_addr_ff   <= skid_addr_ff;
               out_err_ff    <= skid_err_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (push && out_valid_ff && !pop) begin
            skid_addr_ff  <= emit_addr;
            skid_err_ff   <= emit_err;
            skid_valid_ff <= 1'b1;
         end else if (push) begin
            out_addr_ff  <= emit_addr;
            out_err_ff   <= emit_err;
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_err_ff |-> out_addr_ff == '0)
      else $error("error result carries a nonzero address");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_octet_saturated: assert property (@(posedge clock) disable iff (reset)
      octet_ff <= OCTET_SAT)
      else $error("octet accumulator above saturation value");

   a_bad_start_reports: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.start_req && !is_digit |=> out_valid_ff)
      else $error("non-digit at string start gave no result");

endmodule
